@@ hdl/wgw_pkg.sv @@
// shared types, constants and control codes of the graph walk engine
package wgw_pkg;

   // sizes
   localparam int MAX_VERTICES  = 16;
   localparam int VTX_BITS      = $clog2(MAX_VERTICES);
   localparam int CNT_BITS      = VTX_BITS + 1;
   localparam int WEIGHT_BITS   = 8;
   localparam int MAT_DEPTH     = MAX_VERTICES * MAX_VERTICES;
   localparam int MAT_ADDR_BITS = 2 * VTX_BITS;
   localparam int QUEUE_DEPTH   = 256;
   localparam int QUEUE_BITS    = $clog2(QUEUE_DEPTH);
   localparam int DIST_BITS     = 14;
   localparam int TOTAL_BITS    = 12;
   localparam int CFG_BITS      = 5;
   localparam int OP_BITS       = 2;
   localparam int STATUS_BITS   = 2;

   localparam logic [DIST_BITS-1:0]  NO_PATH_DIST  = DIST_BITS'(9999);
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX     = '1;
   localparam logic [CFG_BITS-1:0]   VCOUNT_RESET  = CFG_BITS'(16);

   // request operations
   typedef enum logic [OP_BITS-1:0] {
      OP_ADD_EDGE    = 2'd0,
      OP_DEPTH_FIRST = 2'd1,
      OP_SHORTEST    = 2'd2
   } op_type;

   // result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      logic [OP_BITS-1:0]     operation;
      logic [VTX_BITS-1:0]    first_vertex;
      logic [VTX_BITS-1:0]    second_vertex;
      logic [WEIGHT_BITS-1:0] edge_weight;
   } req_payload_type;

   typedef struct packed {
      logic [VTX_BITS-1:0]    vertex;
      logic [WEIGHT_BITS-1:0] segment_weight;
      logic [TOTAL_BITS-1:0]  total_distance;
      logic [VTX_BITS-1:0]    hop_count;
      logic                   reachable;
      logic [STATUS_BITS-1:0] status;
      logic                   last;
   } rsp_payload_type;

   // controller states
   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_WR_AB, S_WR_BA, S_REPLY,
      S_D_INIT, S_G_RD, S_G_USE, S_S_I, S_S_J, S_COPY,
      S_P_CHK, S_P_USE, S_P_EMIT, S_D_END,
      S_Q_INIT, S_Q_POP, S_Q_LOAD, S_R_RD, S_R_USE,
      S_T_INIT, S_T_STEP, S_E_INIT, S_E_CHK, S_E_SEG, S_E_LAST
   } state_type;

   // datapath micro operations
   typedef enum logic [4:0] {
      U_NONE, U_ACCEPT, U_WR_AB, U_WR_BA, U_REPLY,
      U_D_INIT, U_G_RD, U_G_USE, U_S_I, U_S_J, U_COPY,
      U_P_CHK, U_P_EMIT, U_D_END,
      U_Q_INIT, U_Q_POP, U_Q_LOAD, U_R_RD, U_R_USE,
      U_T_INIT, U_T_STEP, U_E_INIT, U_E_CHK, U_E_SEG, U_E_LAST
   } uop_type;

   typedef struct packed {
      uop_type uop;
   } cmd_type;

   typedef struct packed {
      logic               req_fire;
      logic [OP_BITS-1:0] op;
      logic               bad;
      logic               out_free;
      logic               scan_end;
      logic               sort_i_end;
      logic               sort_j_end;
      logic               copy_end;
      logic               depth_zero;
      logic               frame_has_next;
      logic               nx_new;
      logic               queue_empty;
      logic               trace_end;
      logic               path_more;
   } sts_type;

endpackage

@@ hdl/wgw_ifs.sv @@
// request, result and register write channel interfaces
interface wgw_req_if;
   import wgw_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface wgw_rsp_if;
   import wgw_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface wgw_csr_if;
   import wgw_pkg::*;
   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/wgw_ctrl.sv @@
// sequencing state machine of the graph walk engine
module wgw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  wgw_pkg::sts_type sts,
   output wgw_pkg::cmd_type cmd
);
   import wgw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and command
   always_comb begin
      state_in = state_ff;
      cmd.uop  = U_NONE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.uop = U_ACCEPT;
            if (sts.req_fire) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.bad) begin
               state_in = S_REPLY;
            end else begin
               unique case (sts.op)
                  OP_ADD_EDGE:    state_in = S_WR_AB;
                  OP_DEPTH_FIRST: state_in = S_D_INIT;
                  OP_SHORTEST:    state_in = S_Q_INIT;
                  default:        state_in = S_REPLY;
               endcase
            end
         end
         S_WR_AB: begin
            cmd.uop  = U_WR_AB;
            state_in = S_WR_BA;
         end
         S_WR_BA: begin
            cmd.uop  = U_WR_BA;
            state_in = S_REPLY;
         end
         S_REPLY: begin
            cmd.uop = U_REPLY;
            if (sts.out_free) state_in = S_IDLE;
         end
         S_D_INIT: begin
            cmd.uop  = U_D_INIT;
            state_in = S_G_RD;
         end
         S_G_RD: begin
            cmd.uop  = U_G_RD;
            state_in = S_G_USE;
         end
         S_G_USE: begin
            cmd.uop  = U_G_USE;
            state_in = sts.scan_end ? S_S_I : S_G_RD;
         end
         S_S_I: begin
            cmd.uop  = U_S_I;
            state_in = sts.sort_i_end ? S_COPY : S_S_J;
         end
         S_S_J: begin
            cmd.uop = U_S_J;
            if (sts.sort_j_end) state_in = S_S_I;
         end
         S_COPY: begin
            cmd.uop = U_COPY;
            if (sts.copy_end) state_in = S_P_CHK;
         end
         S_P_CHK: begin
            cmd.uop = U_P_CHK;
            if (sts.depth_zero) begin
               state_in = S_D_END;
            end else if (sts.frame_has_next) begin
               state_in = S_P_USE;
            end
         end
         S_P_USE: begin
            state_in = sts.nx_new ? S_P_EMIT : S_P_CHK;
         end
         S_P_EMIT: begin
            cmd.uop = U_P_EMIT;
            if (sts.out_free) state_in = S_G_RD;
         end
         S_D_END: begin
            cmd.uop = U_D_END;
            if (sts.out_free) state_in = S_IDLE;
         end
         S_Q_INIT: begin
            cmd.uop  = U_Q_INIT;
            state_in = S_Q_POP;
         end
         S_Q_POP: begin
            cmd.uop  = U_Q_POP;
            state_in = sts.queue_empty ? S_T_INIT : S_Q_LOAD;
         end
         S_Q_LOAD: begin
            cmd.uop  = U_Q_LOAD;
            state_in = S_R_RD;
         end
         S_R_RD: begin
            cmd.uop  = U_R_RD;
            state_in = S_R_USE;
         end
         S_R_USE: begin
            cmd.uop  = U_R_USE;
            state_in = sts.scan_end ? S_Q_POP : S_R_RD;
         end
         S_T_INIT: begin
            cmd.uop  = U_T_INIT;
            state_in = S_T_STEP;
         end
         S_T_STEP: begin
            cmd.uop = U_T_STEP;
            if (sts.trace_end) state_in = S_E_INIT;
         end
         S_E_INIT: begin
            cmd.uop  = U_E_INIT;
            state_in = S_E_CHK;
         end
         S_E_CHK: begin
            cmd.uop  = U_E_CHK;
            state_in = sts.path_more ? S_E_SEG : S_E_LAST;
         end
         S_E_SEG: begin
            cmd.uop = U_E_SEG;
            if (sts.out_free) state_in = S_E_CHK;
         end
         S_E_LAST: begin
            cmd.uop = U_E_LAST;
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/wgw_datapath.sv @@
// storage, counters, memories and result register of the graph walk engine
module wgw_datapath (
   input  logic             clock,
   input  logic             reset,
   input  wgw_pkg::cmd_type cmd,
   output wgw_pkg::sts_type sts,
   wgw_req_if.sink          req_if,
   wgw_rsp_if.source        rsp_if,
   wgw_csr_if.sink          csr_if
);
   import wgw_pkg::*;

   // latched request and register
   logic [OP_BITS-1:0]     op_ff;
   logic [VTX_BITS-1:0]    a_ff;
   logic [VTX_BITS-1:0]    b_ff;
   logic [WEIGHT_BITS-1:0] w_ff;
   logic [CFG_BITS-1:0]    vcount_ff;
   logic [CNT_BITS-1:0]    n_act;

   // weight matrix
   logic [WEIGHT_BITS-1:0]   wmem [MAT_DEPTH];
   logic [MAT_DEPTH-1:0]     wvld_ff;
   logic [WEIGHT_BITS-1:0]   wrd_ff;
   logic                     wrd_vld_ff;
   logic [MAT_ADDR_BITS-1:0] w_raddr;
   logic [MAT_ADDR_BITS-1:0] w_waddr;
   logic                     w_we;
   logic                     w_re;
   logic [WEIGHT_BITS-1:0]   w_eff;
   logic [VTX_BITS-1:0]      w_col;

   // depth-first walk
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [VTX_BITS-1:0]     cur_ff;
   logic [VTX_BITS-1:0]     idx_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic [VTX_BITS-1:0]     buf_id_ff [MAX_VERTICES];
   logic [WEIGHT_BITS-1:0]  buf_w_ff [MAX_VERTICES];
   logic [VTX_BITS-1:0]     x_id_ff;
   logic [WEIGHT_BITS-1:0]  x_w_ff;
   logic [CNT_BITS-1:0]     si_ff;
   logic [CNT_BITS-1:0]     sj_ff;
   logic [CNT_BITS-1:0]     ci_ff;
   logic [VTX_BITS-1:0]     buf_sel;
   logic [VTX_BITS-1:0]     buf_rd_id;
   logic [WEIGHT_BITS-1:0]  buf_rd_w;
   logic [VTX_BITS-1:0]     smem [MAT_DEPTH];
   logic [VTX_BITS-1:0]     srd_ff;
   logic [CNT_BITS-1:0]     len_ff [MAX_VERTICES];
   logic [CNT_BITS-1:0]     pos_ff [MAX_VERTICES];
   logic [CNT_BITS-1:0]     dc_ff;
   logic [CNT_BITS-1:0]     dc_m1;
   logic [VTX_BITS-1:0]     d_idx;
   logic [VTX_BITS-1:0]     pend_ff;
   logic                    s_re;

   // relaxation
   logic [VTX_BITS-1:0]     qmem [QUEUE_DEPTH];
   logic [VTX_BITS-1:0]     qrd_ff;
   logic [QUEUE_BITS-1:0]   head_ff;
   logic [QUEUE_BITS:0]     qcnt_ff;
   logic                    q_we;
   logic [QUEUE_BITS-1:0]   q_waddr;
   logic [VTX_BITS-1:0]     q_wdata;
   logic [DIST_BITS-1:0]    best_ff [MAX_VERTICES];
   logic [DIST_BITS-1:0]    du_ff;
   logic [DIST_BITS-1:0]    nd;
   logic [VTX_BITS-1:0]     best_sel;
   logic [DIST_BITS-1:0]    best_rd;
   logic [VTX_BITS-1:0]     par_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] pv_ff;
   logic                    ovf_ff;
   logic                    improve;
   logic                    room;

   // path trace and emission
   logic [VTX_BITS-1:0]   ps_ff [MAX_VERTICES];
   logic [CNT_BITS-1:0]   plen_ff;
   logic [CNT_BITS-1:0]   plen_m1;
   logic [VTX_BITS-1:0]   tv_ff;
   logic                  reach_ff;
   logic [CNT_BITS-1:0]   ei_ff;
   logic [CNT_BITS-1:0]   ei_m2;
   logic [VTX_BITS-1:0]   nxt_ff;
   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS:0]   total_sum;
   logic [TOTAL_BITS-1:0] total_in;
   logic [VTX_BITS-1:0]   ps_sel;
   logic [VTX_BITS-1:0]   ps_rd;
   logic [STATUS_BITS-1:0] sp_status;

   // result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic            out_free;
   logic            out_load;

   // handshakes, held off during reset
   assign req_if.ready   = (cmd.uop == U_ACCEPT) && !reset;
   assign csr_if.ready   = !reset;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign n_act = (vcount_ff > CFG_BITS'(MAX_VERTICES)) ? CNT_BITS'(MAX_VERTICES)
                                                         : CNT_BITS'(vcount_ff);

   // request validity
   always_comb begin
      sts.bad = 1'b1;
      unique case (op_ff)
         OP_ADD_EDGE, OP_SHORTEST:
            sts.bad = (CNT_BITS'(a_ff) >= n_act) || (CNT_BITS'(b_ff) >= n_act);
         OP_DEPTH_FIRST:
            sts.bad = (CNT_BITS'(a_ff) >= n_act);
         default:
            sts.bad = 1'b1;
      endcase
   end

   // weight matrix ports
   assign w_eff   = wrd_vld_ff ? wrd_ff : '0;
   assign w_col   = (cmd.uop == U_E_CHK) ? ps_rd : idx_ff;
   assign w_raddr = {cur_ff, w_col};
   assign w_waddr = (cmd.uop == U_WR_AB) ? {a_ff, b_ff} : {b_ff, a_ff};
   assign w_we    = (cmd.uop == U_WR_AB) || (cmd.uop == U_WR_BA);
   assign w_re    = (cmd.uop == U_G_RD) || (cmd.uop == U_R_RD) ||
                    ((cmd.uop == U_E_CHK) && sts.path_more);

   always_ff @(posedge clock) begin
      if (w_we) wmem[w_waddr] <= w_ff;
      if (w_re) wrd_ff <= wmem[w_raddr];
   end

   // entry valid bits stand in for clearing the matrix
   always_ff @(posedge clock) begin
      if (reset) begin
         wvld_ff    <= '0;
         wrd_vld_ff <= 1'b0;
      end else begin
         if (w_we) wvld_ff[w_waddr] <= 1'b1;
         if (w_re) wrd_vld_ff <= wvld_ff[w_raddr];
      end
   end

   // sort buffer read port
   always_comb begin
      unique case (cmd.uop)
         U_S_I:   buf_sel = si_ff[VTX_BITS-1:0];
         U_S_J:   buf_sel = sj_ff[VTX_BITS-1:0];
         default: buf_sel = ci_ff[VTX_BITS-1:0];
      endcase
   end
   assign buf_rd_id = buf_id_ff[buf_sel];
   assign buf_rd_w  = buf_w_ff[buf_sel];

   // walk stack
   assign dc_m1 = dc_ff - CNT_BITS'(1);
   assign d_idx = dc_m1[VTX_BITS-1:0];
   assign s_re  = (cmd.uop == U_P_CHK) && !sts.depth_zero && sts.frame_has_next;

   always_ff @(posedge clock) begin
      if ((cmd.uop == U_COPY) && !sts.copy_end) begin
         smem[{dc_ff[VTX_BITS-1:0], ci_ff[VTX_BITS-1:0]}] <= buf_rd_id;
      end
      if (s_re) srd_ff <= smem[{d_idx, pos_ff[d_idx][VTX_BITS-1:0]}];
   end

   // relaxation queue
   assign nd      = du_ff + DIST_BITS'(w_eff);
   assign improve = (w_eff != '0) && (nd < best_rd);
   assign room    = (qcnt_ff < (QUEUE_BITS+1)'(QUEUE_DEPTH));
   assign q_we    = (cmd.uop == U_Q_INIT) || ((cmd.uop == U_R_USE) && improve && room);
   assign q_waddr = (cmd.uop == U_Q_INIT) ? '0 : (head_ff + qcnt_ff[QUEUE_BITS-1:0]);
   assign q_wdata = (cmd.uop == U_Q_INIT) ? a_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (q_we) qmem[q_waddr] <= q_wdata;
      if ((cmd.uop == U_Q_POP) && !sts.queue_empty) qrd_ff <= qmem[head_ff];
   end

   // distance read port
   always_comb begin
      unique case (cmd.uop)
         U_Q_LOAD: best_sel = qrd_ff;
         U_T_INIT: best_sel = b_ff;
         default:  best_sel = idx_ff;
      endcase
   end
   assign best_rd = best_ff[best_sel];

   // path store read port
   assign plen_m1 = plen_ff - CNT_BITS'(1);
   assign ei_m2   = ei_ff - CNT_BITS'(2);
   assign ps_sel  = (cmd.uop == U_E_INIT) ? plen_m1[VTX_BITS-1:0] : ei_m2[VTX_BITS-1:0];
   assign ps_rd   = ps_ff[ps_sel];

   // saturating path total
   assign total_sum = {1'b0, total_ff} + (TOTAL_BITS+1)'(w_eff);
   assign total_in  = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
   assign sp_status = ovf_ff ? ST_OVERFLOW : ST_OK;

   // status to the controller
   assign sts.req_fire       = req_if.valid && req_if.ready;
   assign sts.op             = op_ff;
   assign sts.out_free       = out_free;
   assign sts.scan_end       = ((CNT_BITS'(idx_ff) + CNT_BITS'(1)) == n_act);
   assign sts.sort_i_end     = (si_ff >= cnt_ff);
   assign sts.sort_j_end     = (sj_ff >= cnt_ff);
   assign sts.copy_end       = (ci_ff >= cnt_ff);
   assign sts.depth_zero     = (dc_ff == '0);
   assign sts.frame_has_next = (pos_ff[d_idx] < len_ff[d_idx]);
   assign sts.nx_new         = !visited_ff[srd_ff] && (dc_ff < CNT_BITS'(MAX_VERTICES));
   assign sts.queue_empty    = (qcnt_ff == '0);
   assign sts.trace_end      = !pv_ff[tv_ff] ||
                               ((plen_ff + CNT_BITS'(1)) >= CNT_BITS'(MAX_VERTICES));
   assign sts.path_more      = (ei_ff > CNT_BITS'(1));

   // request latch and register write
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         vcount_ff <= csr_if.data;
      end
   end

   always_ff @(posedge clock) begin
      if (sts.req_fire) begin
         op_ff <= req_if.payload.operation;
         a_ff  <= req_if.payload.first_vertex;
         b_ff  <= req_if.payload.second_vertex;
         w_ff  <= req_if.payload.edge_weight;
      end
   end

   // visited marks
   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
      end else if (cmd.uop == U_D_INIT) begin
         visited_ff       <= '0;
         visited_ff[a_ff] <= 1'b1;
      end else if ((cmd.uop == U_P_EMIT) && out_free) begin
         visited_ff[srd_ff] <= 1'b1;
      end
   end

   // walk and relaxation working registers
   always_ff @(posedge clock) begin
      unique case (cmd.uop)
         U_D_INIT: begin
            cur_ff  <= a_ff;
            pend_ff <= a_ff;
            dc_ff   <= '0;
            idx_ff  <= '0;
            cnt_ff  <= '0;
            si_ff   <= '0;
            ci_ff   <= '0;
         end
         U_G_USE: begin
            if ((w_eff != '0) && !visited_ff[idx_ff]) begin
               buf_id_ff[cnt_ff[VTX_BITS-1:0]] <= idx_ff;
               buf_w_ff[cnt_ff[VTX_BITS-1:0]]  <= w_eff;
               cnt_ff <= cnt_ff + CNT_BITS'(1);
            end
            idx_ff <= idx_ff + VTX_BITS'(1);
         end
         U_S_I: begin
            if (!sts.sort_i_end) begin
               x_id_ff <= buf_rd_id;
               x_w_ff  <= buf_rd_w;
               sj_ff   <= si_ff + CNT_BITS'(1);
            end
         end
         U_S_J: begin
            if (!sts.sort_j_end) begin
               // exchange when the later weight is smaller
               if (buf_rd_w < x_w_ff) begin
                  buf_id_ff[sj_ff[VTX_BITS-1:0]] <= x_id_ff;
                  buf_w_ff[sj_ff[VTX_BITS-1:0]]  <= x_w_ff;
                  x_id_ff <= buf_rd_id;
                  x_w_ff  <= buf_rd_w;
               end
               sj_ff <= sj_ff + CNT_BITS'(1);
            end else begin
               buf_id_ff[si_ff[VTX_BITS-1:0]] <= x_id_ff;
               buf_w_ff[si_ff[VTX_BITS-1:0]]  <= x_w_ff;
               si_ff <= si_ff + CNT_BITS'(1);
            end
         end
         U_COPY: begin
            if (!sts.copy_end) begin
               ci_ff <= ci_ff + CNT_BITS'(1);
            end else begin
               len_ff[dc_ff[VTX_BITS-1:0]] <= cnt_ff;
               pos_ff[dc_ff[VTX_BITS-1:0]] <= '0;
               dc_ff <= dc_ff + CNT_BITS'(1);
            end
         end
         U_P_CHK: begin
            if (!sts.depth_zero) begin
               if (sts.frame_has_next) begin
                  pos_ff[d_idx] <= pos_ff[d_idx] + CNT_BITS'(1);
               end else begin
                  dc_ff <= dc_m1;
               end
            end
         end
         U_P_EMIT: begin
            if (out_free) begin
               pend_ff <= srd_ff;
               cur_ff  <= srd_ff;
               idx_ff  <= '0;
               cnt_ff  <= '0;
               si_ff   <= '0;
               ci_ff   <= '0;
            end
         end
         U_Q_INIT: begin
            for (int k = 0; k < MAX_VERTICES; k++) begin
               best_ff[k] <= NO_PATH_DIST;
            end
            best_ff[a_ff] <= '0;
            pv_ff   <= '0;
            head_ff <= '0;
            qcnt_ff <= (QUEUE_BITS+1)'(1);
            ovf_ff  <= 1'b0;
         end
         U_Q_POP: begin
            if (!sts.queue_empty) begin
               head_ff <= head_ff + QUEUE_BITS'(1);
               qcnt_ff <= qcnt_ff - (QUEUE_BITS+1)'(1);
            end
         end
         U_Q_LOAD: begin
            cur_ff <= qrd_ff;
            du_ff  <= best_rd;
            idx_ff <= '0;
         end
         U_R_USE: begin
            if (improve) begin
               best_ff[idx_ff] <= nd;
               par_ff[idx_ff]  <= cur_ff;
               pv_ff[idx_ff]   <= 1'b1;
               if (room) begin
                  qcnt_ff <= qcnt_ff + (QUEUE_BITS+1)'(1);
               end else begin
                  ovf_ff <= 1'b1;
               end
            end
            idx_ff <= idx_ff + VTX_BITS'(1);
         end
         U_T_INIT: begin
            tv_ff    <= b_ff;
            plen_ff  <= '0;
            reach_ff <= (best_rd < NO_PATH_DIST);
         end
         U_T_STEP: begin
            ps_ff[plen_ff[VTX_BITS-1:0]] <= tv_ff;
            plen_ff <= plen_ff + CNT_BITS'(1);
            tv_ff   <= par_ff[tv_ff];
         end
         U_E_INIT: begin
            cur_ff   <= ps_rd;
            ei_ff    <= plen_ff;
            total_ff <= '0;
         end
         U_E_CHK: begin
            if (sts.path_more) nxt_ff <= ps_rd;
         end
         U_E_SEG: begin
            if (out_free) begin
               total_ff <= total_in;
               cur_ff   <= nxt_ff;
               ei_ff    <= ei_ff - CNT_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // result payload
   always_comb begin
      rsp_data_in = '0;
      out_load    = 1'b0;
      unique case (cmd.uop)
         U_REPLY: begin
            out_load           = 1'b1;
            rsp_data_in.status = sts.bad ? ST_BAD_INDEX : ST_OK;
            rsp_data_in.last   = 1'b1;
         end
         U_P_EMIT: begin
            out_load           = 1'b1;
            rsp_data_in.vertex = pend_ff;
         end
         U_D_END: begin
            out_load           = 1'b1;
            rsp_data_in.vertex = pend_ff;
            rsp_data_in.last   = 1'b1;
         end
         U_E_SEG: begin
            out_load                   = 1'b1;
            rsp_data_in.vertex         = cur_ff;
            rsp_data_in.segment_weight = w_eff;
            rsp_data_in.reachable      = reach_ff;
            rsp_data_in.status         = sp_status;
         end
         U_E_LAST: begin
            out_load                   = 1'b1;
            rsp_data_in.vertex         = cur_ff;
            rsp_data_in.total_distance = total_ff;
            rsp_data_in.hop_count      = plen_m1[VTX_BITS-1:0];
            rsp_data_in.reachable      = reach_ff;
            rsp_data_in.status         = sp_status;
            rsp_data_in.last           = 1'b1;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // output register
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && out_load) rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hdl/weighted_graph_walk_engine_core.sv @@
// top level of the graph walk engine: controller and datapath
// add edge: decode, write of both matrix entries, then the result; the next request waits for the result register
// depth-first walk: the weight row of each visited vertex is scanned through the weight memory port,
//   then its unvisited neighbours are sorted by weight and stacked
// shortest path: the weight row of each dequeued vertex is read on the single weight memory read port,
//   then the path is traced back vertex by vertex and one result is given per path vertex
// reset (synchronous): weight matrix entry valid bits clear at once, no clearing pass;
//   vertex count returns to 16 and the block takes a request once reset is released
module weighted_graph_walk_engine_core (
   input logic       clock,
   input logic       reset,
   wgw_req_if.sink   req_if,
   wgw_rsp_if.source rsp_if,
   wgw_csr_if.sink   csr_if
);
   import wgw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   wgw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // storage and arithmetic
   wgw_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

endmodule
